FILE: design/tlfc_pkg.sv
`default_nettype none
package tlfc_pkg;

  localparam int TAG_W          = 10;
  localparam int WORD_W         = 32;
  localparam int NEAR_DEPTH_DEF = 64;
  localparam int FAR_DEPTH_DEF  = 128;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [1:0] LVL_NEAR = 2'd0;
  localparam logic [1:0] LVL_FAR  = 2'd1;
  localparam logic [1:0] LVL_MISS = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [WORD_W-1:0] data;
  } entry_t;

  // Broadcast to every cell of one level.
  typedef struct packed {
    logic              advance;  // every cell takes its upper neighbor's entry
    logic              wrap;     // the top cell takes the head entry (rotate)
    logic              fill;     // first empty cell takes the fresh entry
    logic              update;   // matching cells take wdata
    logic [TAG_W-1:0]  probe;
    logic [WORD_W-1:0] wdata;
    entry_t            fresh;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

endpackage
`default_nettype wire

FILE: design/tlfc_cell.sv
`default_nettype none
module tlfc_cell (
  input  logic                clk,
  input  logic                rst,
  input  tlfc_pkg::cell_ctl_t ctl,
  input  tlfc_pkg::entry_t    up,
  input  logic                prev_valid,
  output tlfc_pkg::entry_t    ent,
  output tlfc_pkg::entry_t    eff,
  output logic                match
);
  import tlfc_pkg::*;

  entry_t ent_next;

  assign match = ent.valid && (ent.tag == ctl.probe);

  // Entry as seen after a write update in this cycle.
  always_comb begin
    eff = ent;
    if (ctl.update && match) begin
      eff.data = ctl.wdata;
    end
  end

  always_comb begin
    ent_next = eff;
    if (ctl.advance) begin
      ent_next = up;
    end else if (ctl.fill && !ent.valid && prev_valid) begin
      ent_next = ctl.fresh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
    end
    ent.tag  <= ent_next.tag;
    ent.data <= ent_next.data;
  end

endmodule
`default_nettype wire

FILE: design/tlfc_chain.sv
`default_nettype none
module tlfc_chain #(
  parameter int DEPTH = tlfc_pkg::NEAR_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  tlfc_pkg::cell_ctl_t ctl,
  input  tlfc_pkg::entry_t    tail_in,
  output tlfc_pkg::entry_t    head,
  output logic                head_match,
  output logic                full,
  output logic                empty
);
  import tlfc_pkg::*;

  entry_t ent [DEPTH];
  entry_t eff [DEPTH];
  logic   match [DEPTH];
  entry_t top_in;

  // Rotation feeds the head back to the top; a shift brings in the new tail.
  assign top_in = ctl.wrap ? eff[0] : tail_in;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t up;
    logic   prev_valid;

    if (i == DEPTH - 1) begin : g_top
      assign up = top_in;
    end else begin : g_mid
      assign up = eff[i+1];
    end

    if (i == 0) begin : g_bottom
      assign prev_valid = 1'b1;
    end else begin : g_rest
      assign prev_valid = ent[i-1].valid;
    end

    tlfc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .up         (up),
      .prev_valid (prev_valid),
      .ent        (ent[i]),
      .eff        (eff[i]),
      .match      (match[i])
    );
  end

  assign head       = eff[0];
  assign head_match = match[0];
  assign full       = ent[DEPTH-1].valid;
  assign empty      = !ent[0].valid;

endmodule
`default_nettype wire

FILE: design/two_level_fifo_cache.sv
`default_nettype none
// Two-level fully associative cache, each level a packed FIFO row of cells.
// Request channel: drive req_type, address, write_data and backing_word with
// start high; the item is taken at a rising edge with start high and busy low.
// backing_word is the memory word at address; it answers a read miss and is
// the word filled on a read miss and on every write.
// Result channel: done is high for exactly one cycle with read_data and
// hit_level (0 near hit, 1 far hit, 2 miss); read_data is zero for writes.
// The receiver cannot stall the result; it must take it in that cycle.
// Sequence: an item rotates each cell row once past its head compare in
// ST_SCAN, then updates and fills in ST_APPLY; done is registered from
// ST_APPLY. Items do not overlap: a new item is taken only once the block
// is idle again, which it is in the cycle done is shown. The length of the
// longer row sets how long the scan lasts.
// Reset clears every valid bit, so both levels come up empty, and returns the
// block to idle with no result pending.
module two_level_fifo_cache #(
  parameter int NEAR_DEPTH = tlfc_pkg::NEAR_DEPTH_DEF,
  parameter int FAR_DEPTH  = tlfc_pkg::FAR_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                req_type,
  input  logic        [tlfc_pkg::TAG_W-1:0]   address,
  input  logic signed [tlfc_pkg::WORD_W-1:0]  write_data,
  input  logic signed [tlfc_pkg::WORD_W-1:0]  backing_word,
  output logic                                done,
  output logic signed [tlfc_pkg::WORD_W-1:0]  read_data,
  output logic        [1:0]                   hit_level
);
  import tlfc_pkg::*;

  localparam int MAX_DEPTH = (NEAR_DEPTH > FAR_DEPTH) ? NEAR_DEPTH : FAR_DEPTH;
  localparam int CW        = $clog2(MAX_DEPTH);

  state_t            state, state_next;
  logic [CW-1:0]     cnt;
  logic              req_q;
  logic [TAG_W-1:0]  tag_q;
  logic [WORD_W-1:0] wdata_q;
  logic [WORD_W-1:0] bword_q;
  logic              nfound, ffound;
  logic [WORD_W-1:0] ndata, fdata;

  logic      accept;
  logic      scan_last;
  logic      near_adv, far_adv;
  logic      do_fill, shift;
  cell_ctl_t near_ctl, far_ctl;
  entry_t    fresh;
  entry_t    near_head, far_head;
  logic      near_head_match, far_head_match;
  logic      near_full, far_full, near_empty, far_empty;

  assign accept    = start && !busy;
  assign scan_last = (cnt == CW'(MAX_DEPTH - 1));
  assign fresh     = '{valid: 1'b1, tag: tag_q, data: bword_q};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_SCAN;
      ST_SCAN:  if (scan_last) state_next = ST_APPLY;
      ST_APPLY: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = (state != ST_IDLE);
    near_adv = (state == ST_SCAN) && ({1'b0, cnt} < (CW+1)'(NEAR_DEPTH));
    far_adv  = (state == ST_SCAN) && ({1'b0, cnt} < (CW+1)'(FAR_DEPTH));
    do_fill  = (state == ST_APPLY) && ((req_q == REQ_WRITE) || (!nfound && !ffound));
    shift    = do_fill && near_full && far_full;

    near_ctl.advance = near_adv || shift;
    near_ctl.wrap    = near_adv;
    near_ctl.fill    = do_fill && !near_full;
    near_ctl.update  = (state == ST_APPLY) && (req_q == REQ_WRITE) && nfound;
    near_ctl.probe   = tag_q;
    near_ctl.wdata   = wdata_q;
    near_ctl.fresh   = fresh;

    far_ctl.advance = far_adv || shift;
    far_ctl.wrap    = far_adv;
    far_ctl.fill    = do_fill && near_full && !far_full;
    far_ctl.update  = (state == ST_APPLY) && (req_q == REQ_WRITE) && !nfound && ffound;
    far_ctl.probe   = tag_q;
    far_ctl.wdata   = wdata_q;
    far_ctl.fresh   = fresh;
  end

  tlfc_chain #(.DEPTH(NEAR_DEPTH)) u_near (
    .clk        (clk),
    .rst        (rst),
    .ctl        (near_ctl),
    .tail_in    (fresh),
    .head       (near_head),
    .head_match (near_head_match),
    .full       (near_full),
    .empty      (near_empty)
  );

  // Demoted oldest near entry lands on the far tail.
  tlfc_chain #(.DEPTH(FAR_DEPTH)) u_far (
    .clk        (clk),
    .rst        (rst),
    .ctl        (far_ctl),
    .tail_in    (near_head),
    .head       (far_head),
    .head_match (far_head_match),
    .full       (far_full),
    .empty      (far_empty)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      nfound <= 1'b0;
      ffound <= 1'b0;
      done   <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_APPLY);
      if (accept) begin
        cnt    <= '0;
        nfound <= 1'b0;
        ffound <= 1'b0;
      end else if (state == ST_SCAN) begin
        cnt <= cnt + 1'b1;
        // Heads pass in index order, so the first hit is the lowest index.
        if (near_adv && near_head_match && !nfound) begin
          nfound <= 1'b1;
        end
        if (far_adv && far_head_match && !ffound) begin
          ffound <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q   <= req_type;
      tag_q   <= address;
      wdata_q <= write_data;
      bword_q <= backing_word;
    end
    if (near_adv && near_head_match && !nfound) begin
      ndata <= near_head.data;
    end
    if (far_adv && far_head_match && !ffound) begin
      fdata <= far_head.data;
    end
    if (state == ST_APPLY) begin
      if (req_q == REQ_WRITE) begin
        read_data <= '0;
      end else if (nfound) begin
        read_data <= ndata;
      end else if (ffound) begin
        read_data <= fdata;
      end else begin
        read_data <= bword_q;
      end
      hit_level <= nfound ? LVL_NEAR : (ffound ? LVL_FAR : LVL_MISS);
    end
  end

  a_done_after_apply: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_APPLY))
    else $error("result strobe without an apply cycle");

  a_far_needs_full_near: assert property (@(posedge clk) disable iff (rst)
    !far_empty |-> near_full)
    else $error("far level holds entries while near level has room");

  a_empty_near_empty_far: assert property (@(posedge clk) disable iff (rst)
    near_empty |-> far_empty)
    else $error("far level holds entries while near level is empty");

  a_idle_gives_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> done)
    else $error("item finished without a result");

  a_write_reads_zero: assert property (@(posedge clk) disable iff (rst)
    done && (req_q == REQ_WRITE) |-> (read_data == '0))
    else $error("write result carries nonzero data");

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none
module tb_top;
  import tlfc_pkg::*;

  localparam int NEAR_DEPTH   = NEAR_DEPTH_DEF;
  localparam int FAR_DEPTH    = FAR_DEPTH_DEF;
  localparam int ITEM_CYCLES  = ((NEAR_DEPTH > FAR_DEPTH) ? NEAR_DEPTH : FAR_DEPTH) + 2;
  localparam int DRAIN_CYCLES = ITEM_CYCLES + 10;
  localparam int STALL_LIMIT  = 8 * (ITEM_CYCLES + 6);
  localparam int N_DIRECTED   = 17;
  localparam int N_RANDOM     = 1633;
  localparam int CALM_TAIL    = 150;

  typedef struct {
    logic              req;
    logic [TAG_W-1:0]  addr;
    logic [WORD_W-1:0] wdata;
    logic [WORD_W-1:0] bword;
    bit                typed;
    logic [WORD_W-1:0] rd;
    logic [1:0]        lvl;
  } access_row_t;

  typedef struct {
    int                seq;
    logic [WORD_W-1:0] rd;
    logic [1:0]        lvl;
  } answer_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      req_type = REQ_READ;
  logic        [TAG_W-1:0]   address = '0;
  logic signed [WORD_W-1:0]  write_data = '0;
  logic signed [WORD_W-1:0]  backing_word = '0;
  logic                      done;
  logic signed [WORD_W-1:0]  read_data;
  logic        [1:0]         hit_level;

  // Side band that travels with the item on the request ports.
  bit                row_typed = 1'b0;
  logic [WORD_W-1:0] typed_rd = '0;
  logic [1:0]        typed_lvl = LVL_MISS;

  logic [TAG_W-1:0]  near_tag  [NEAR_DEPTH];
  logic [WORD_W-1:0] near_word [NEAR_DEPTH];
  bit                near_vld  [NEAR_DEPTH];
  logic [TAG_W-1:0]  far_tag   [FAR_DEPTH];
  logic [WORD_W-1:0] far_word  [FAR_DEPTH];
  bit                far_vld   [FAR_DEPTH];

  answer_t pending_answers[$];
  int      mismatches = 0;
  int      items_taken = 0;
  int      answers_seen = 0;
  int      writes_taken = 0;
  int      level_count [3] = '{0, 0, 0};
  int      demotions = 0;
  int      idle_cycles = 0;

  access_row_t directed_rows [N_DIRECTED] = '{
    '{REQ_READ,  10'd0,   32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, LVL_MISS},
    '{REQ_READ,  10'd0,   32'hDEAD_BEEF, 32'h0000_0001, 1'b1, 32'h7FFF_FFFF, LVL_NEAR},
    '{REQ_WRITE, 10'd0,   32'h8000_0000, 32'h0000_0005, 1'b1, 32'h0000_0000, LVL_NEAR},
    '{REQ_READ,  10'd0,   32'h0000_0000, 32'h0000_0000, 1'b1, 32'h8000_0000, LVL_NEAR},
    '{REQ_WRITE, 10'd0,   32'h0000_1234, 32'h0000_0009, 1'b1, 32'h0000_0000, LVL_NEAR},
    '{REQ_READ,  10'd0,   32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_1234, LVL_NEAR},
    '{REQ_READ,  10'h3FF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, LVL_MISS},
    '{REQ_READ,  10'h3FF, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, LVL_NEAR},
    '{REQ_WRITE, 10'h2AA, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000, LVL_MISS},
    '{REQ_READ,  10'h2AA, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, LVL_NEAR},
    '{REQ_WRITE, 10'h155, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0000_0000, LVL_MISS},
    '{REQ_READ,  10'h155, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h8000_0000, LVL_NEAR},
    '{REQ_WRITE, 10'h3FF, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, LVL_NEAR},
    '{REQ_READ,  10'h3FF, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, LVL_NEAR},
    '{REQ_READ,  10'h0C8, 32'h0000_0000, 32'h1234_5678, 1'b1, 32'h1234_5678, LVL_MISS},
    '{REQ_WRITE, 10'h0C8, 32'h0F0F_0F0F, 32'h1357_9BDF, 1'b0, 32'h0000_0000, LVL_MISS},
    '{REQ_READ,  10'h0C8, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000, LVL_MISS}
  };

  two_level_fifo_cache #(
    .NEAR_DEPTH(NEAR_DEPTH),
    .FAR_DEPTH (FAR_DEPTH)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .address     (address),
    .write_data  (write_data),
    .backing_word(backing_word),
    .done        (done),
    .read_data   (read_data),
    .hit_level   (hit_level)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // First empty near slot, else first empty far slot, else demote near head.
  function automatic void cache_fill(input logic [TAG_W-1:0] tag,
                                     input logic [WORD_W-1:0] word);
    for (int i = 0; i < NEAR_DEPTH; i++) begin
      if (!near_vld[i]) begin
        near_vld[i]  = 1'b1;
        near_tag[i]  = tag;
        near_word[i] = word;
        return;
      end
    end
    for (int i = 0; i < FAR_DEPTH; i++) begin
      if (!far_vld[i]) begin
        far_vld[i]  = 1'b1;
        far_tag[i]  = tag;
        far_word[i] = word;
        return;
      end
    end
    demotions++;
    for (int i = 1; i < FAR_DEPTH; i++) begin
      far_tag[i-1]  = far_tag[i];
      far_word[i-1] = far_word[i];
      far_vld[i-1]  = far_vld[i];
    end
    far_tag[FAR_DEPTH-1]  = near_tag[0];
    far_word[FAR_DEPTH-1] = near_word[0];
    far_vld[FAR_DEPTH-1]  = 1'b1;
    for (int i = 1; i < NEAR_DEPTH; i++) begin
      near_tag[i-1]  = near_tag[i];
      near_word[i-1] = near_word[i];
      near_vld[i-1]  = near_vld[i];
    end
    near_tag[NEAR_DEPTH-1]  = tag;
    near_word[NEAR_DEPTH-1] = word;
    near_vld[NEAR_DEPTH-1]  = 1'b1;
  endfunction

  function automatic answer_t cache_access(input logic req,
                                           input logic [TAG_W-1:0] tag,
                                           input logic [WORD_W-1:0] wdata,
                                           input logic [WORD_W-1:0] bword);
    answer_t ans;
    int      near_hit;
    int      far_hit;
    near_hit = -1;
    far_hit  = -1;
    for (int i = NEAR_DEPTH - 1; i >= 0; i--)
      if (near_vld[i] && near_tag[i] == tag) near_hit = i;
    for (int i = FAR_DEPTH - 1; i >= 0; i--)
      if (far_vld[i] && far_tag[i] == tag) far_hit = i;
    ans.seq = 0;
    ans.rd  = '0;
    if (near_hit >= 0) ans.lvl = LVL_NEAR;
    else if (far_hit >= 0) ans.lvl = LVL_FAR;
    else ans.lvl = LVL_MISS;
    if (req == REQ_READ) begin
      if (near_hit >= 0) begin
        ans.rd = near_word[near_hit];
      end else if (far_hit >= 0) begin
        ans.rd = far_word[far_hit];
      end else begin
        cache_fill(tag, bword);
        ans.rd = bword;
      end
    end else begin
      // Update every match in the chosen level, then fill regardless.
      if (near_hit >= 0) begin
        for (int i = 0; i < NEAR_DEPTH; i++)
          if (near_vld[i] && near_tag[i] == tag) near_word[i] = wdata;
      end else if (far_hit >= 0) begin
        for (int i = 0; i < FAR_DEPTH; i++)
          if (far_vld[i] && far_tag[i] == tag) far_word[i] = wdata;
      end
      cache_fill(tag, bword);
    end
    return ans;
  endfunction

  // Check results before taking the item of this edge: done is registered.
  always @(posedge clk) begin
    answer_t head;
    answer_t pred;
    if (rst) begin
      for (int i = 0; i < NEAR_DEPTH; i++) near_vld[i] = 1'b0;
      for (int i = 0; i < FAR_DEPTH; i++) far_vld[i] = 1'b0;
      pending_answers.delete();
    end else begin
      if (done) begin
        answers_seen++;
        if (pending_answers.size() == 0) begin
          report_mismatch($sformatf("result rd=%h lvl=%0d with no item outstanding",
                                    read_data, hit_level));
        end else begin
          head = pending_answers.pop_front();
          if (read_data !== head.rd)
            report_mismatch($sformatf("item %0d read_data %h, want %h",
                                      head.seq, read_data, head.rd));
          if (hit_level !== head.lvl)
            report_mismatch($sformatf("item %0d hit_level %0d, want %0d",
                                      head.seq, hit_level, head.lvl));
          level_count[head.lvl]++;
        end
      end
      if (start && !busy) begin
        pred = cache_access(req_type, address, write_data, backing_word);
        if (row_typed) begin
          pred.rd  = typed_rd;
          pred.lvl = typed_lvl;
        end
        pred.seq = items_taken;
        pending_answers.push_back(pred);
        items_taken++;
        if (req_type == REQ_WRITE) writes_taken++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("two_level_fifo_cache verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic send_access(input access_row_t row);
    req_type     <= row.req;
    address      <= row.addr;
    write_data   <= row.wdata;
    backing_word <= row.bword;
    row_typed    <= row.typed;
    typed_rd     <= row.rd;
    typed_lvl    <= row.lvl;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    access_row_t row;
    logic [TAG_W-1:0] hot_base;
    int sel;
    hot_base = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[k]) send_access(directed_rows[k]);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 128 == 0) hot_base = TAG_W'($urandom_range(0, 1023 - 16));
      row.req   = ($urandom_range(0, 9) < 4) ? REQ_WRITE : REQ_READ;
      row.wdata = rand_word();
      row.bword = rand_word();
      row.typed = 1'b0;
      row.rd    = '0;
      row.lvl   = LVL_MISS;
      // Mostly revisit a small hot set or a mid-size pool so both levels hit.
      sel = $urandom_range(0, 9);
      if (sel < 5) row.addr = TAG_W'(hot_base + $urandom_range(0, 15));
      else if (sel < 8) row.addr = TAG_W'($urandom_range(0, 255));
      else row.addr = TAG_W'($urandom_range(0, 1023));

      if (n == N_RANDOM / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0) @(posedge clk);
      end else if (n < N_RANDOM - CALM_TAIL && (n / 100) % 3 != 2) begin
        sel = $urandom_range(0, 9);
        if (sel < 2) begin
          hold_off($urandom_range(1, 5));
        end else if (sel < 4) begin
          // Idle right as the block frees up.
          start <= 1'b0;
          @(posedge clk);
          while (busy) @(posedge clk);
          repeat ($urandom_range(1, 5)) @(posedge clk);
        end
      end
      send_access(row);
    end

    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_answers.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_answers.size()));

    $display("covered %0d items (%0d writes), %0d results: near hits %0d, far hits %0d, misses %0d",
             items_taken, writes_taken, answers_seen,
             level_count[LVL_NEAR], level_count[LVL_FAR], level_count[LVL_MISS]);
    $display("demotions from near to far level: %0d, mismatches: %0d", demotions, mismatches);
    if (mismatches == 0) begin
      $display("two_level_fifo_cache verification clean");
    end else begin
      $display("two_level_fifo_cache verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
